// File: hw/rtl/tdt_pkg.sv
`default_nettype none

package tdt_pkg;

	localparam int TASK_W      = 4;
	localparam int TICK_W      = 32;
	localparam int SLICE_W     = 32;
	localparam int RELOAD_W    = 16;
	localparam int MAX_TASKS_DEFAULT = 16;
	localparam int SLICE_RELOAD_DEFAULT = 10;

	typedef enum logic [1:0] {
		OP_DELAY  = 2'd0,
		OP_WAKE   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_WOKEN = 2'd0,
		KIND_SLICE = 2'd1,
		KIND_ACK   = 2'd2
	} kind_t;

	// One entry of the delay set.
	typedef struct packed {
		logic [TASK_W-1:0] id;
		logic [TICK_W-1:0] count;
		logic              ev;
	} entry_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic tick_step;  // shift toward the head
		logic take_head;  // load the decremented head instead of the neighbor
		logic drop;       // close the gap left by a matching task
		logic write;      // load the entry of a delay op
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/tdt_cell.sv
`default_nettype none

// One slot of the ordered delay set. Slots form a chain: during a tick
// or at and past a removed task, each slot takes its upper neighbor.
module tdt_cell (
	input  wire                                clk,
	input  wire tdt_pkg::cell_ctl_t            ctl,
	input  wire tdt_pkg::entry_t               next_ent,
	input  wire tdt_pkg::entry_t               head_ent,
	input  wire tdt_pkg::entry_t               new_ent,
	input  wire                                active,
	input  wire [tdt_pkg::TASK_W-1:0]          tid,
	input  wire                                hit_prior,
	output logic                               hit,
	output logic                               hit_upto,
	output tdt_pkg::entry_t                    ent
);

	tdt_pkg::entry_t ent_q;

	assign hit      = active && (ent_q.id == tid);
	assign hit_upto = hit_prior || hit;
	assign ent      = ent_q;

	always_ff @(posedge clk) begin
		if (ctl.tick_step) begin
			ent_q <= ctl.take_head ? head_ent : next_ent;
		end else if (ctl.drop && hit_upto) begin
			ent_q <= next_ent;
		end else if (ctl.write) begin
			ent_q <= new_ent;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/tdt_slice.sv
`default_nettype none

// Per-task time slices; each step decrements or reloads the running task.
module tdt_slice #(
	parameter int MAX_TASKS     = tdt_pkg::MAX_TASKS_DEFAULT,
	parameter int SLICE_DEFAULT = tdt_pkg::SLICE_RELOAD_DEFAULT
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              step,
	input  wire [tdt_pkg::TASK_W-1:0]        cur,
	input  wire                              peers,
	input  wire [tdt_pkg::RELOAD_W-1:0]      reload,
	output logic                             rotate
);

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	logic [tdt_pkg::SLICE_W-1:0] slice_q [MAX_TASKS];
	logic [31:0]                 cur_ext;
	logic [IDX_W-1:0]            idx;
	logic                        in_range;
	logic [tdt_pkg::SLICE_W-1:0] dec;

	assign cur_ext  = 32'(cur);
	assign idx      = cur_ext[IDX_W-1:0];
	assign in_range = cur_ext < 32'(MAX_TASKS);
	assign dec      = in_range ? slice_q[idx] - 1'b1 : '1;
	assign rotate   = in_range && peers && (dec == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				slice_q[i] <= tdt_pkg::SLICE_W'(SLICE_DEFAULT);
			end
		end else if (step && in_range) begin
			slice_q[idx] <= rotate ? tdt_pkg::SLICE_W'(reload) : dec;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/task_delay_tick_timer.sv
`default_nettype none

// Delay set and tick timer for up to MAX_TASKS tasks. Send one beat per
// operation on the s_axis side: delay, wake and remove answer with a
// single acknowledge beat; a tick answers with one beat per expired task,
// in the order the tasks entered the set, and closes with a slice status
// beat (tlast high). The set lives in a chain of MAX_TASKS cells that
// keeps the entries packed in order. A set-up op registers its
// acknowledge once the output slot is free and returns to idle, where
// the next beat is taken. A tick walks the delayed tasks: the chain
// advances one cell per cycle and the single decrementer at its head
// handles one entry per cycle while the output slot is free; then the
// walk closes, and the running task's slice is updated in the slice
// state, which presents the slice status beat. A stalled m_axis side
// holds the sequence. Write the slice reload only while idle.
module task_delay_tick_timer #(
	parameter int MAX_TASKS     = tdt_pkg::MAX_TASKS_DEFAULT,
	parameter int SLICE_DEFAULT = tdt_pkg::SLICE_RELOAD_DEFAULT
) (
	input  wire         clk,
	input  wire         arst_n,
	// slice reload register
	input  wire         cfg_wen,
	input  wire [15:0]  cfg_wdata,
	// operation beats
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: task_id[3:0], delay_ticks[35:4], event_wait[36],
	//        current_task[40:37], peers_ready[41], zero fill[47:42]
	input  wire [47:0]  s_axis_tdata,
	// tuser: op[1:0]
	input  wire [1:0]   s_axis_tuser,
	// result beats
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// tdata: woken_task[3:0], timed_out[4], rotate[5], zero fill[7:6]
	output logic [7:0]  m_axis_tdata,
	// tuser: kind[1:0]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SETUP = 4'b0010,
		ST_TICK  = 4'b0100,
		ST_SLICE = 4'b1000
	} state_t;

	state_t                           state_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [CNT_W-1:0]                 rem_q;
	logic [tdt_pkg::RELOAD_W-1:0]     reload_q;

	// latched operation
	tdt_pkg::op_t                     op_q;
	logic [tdt_pkg::TASK_W-1:0]       tid_q;
	logic [tdt_pkg::TICK_W-1:0]       ticks_q;
	logic                             ev_q;
	logic [tdt_pkg::TASK_W-1:0]       cur_q;
	logic                             peers_q;

	// output register
	logic                             out_valid_q;
	tdt_pkg::kind_t                   out_kind_q;
	logic [tdt_pkg::TASK_W-1:0]       out_task_q;
	logic                             out_tmo_q;
	logic                             out_rot_q;
	logic                             out_last_q;

	// chain
	tdt_pkg::cell_ctl_t               ctl [MAX_TASKS];
	tdt_pkg::entry_t                  ent [MAX_TASKS];
	logic [MAX_TASKS-1:0]             hit;
	logic [MAX_TASKS-1:0]             hit_upto;
	tdt_pkg::entry_t                  head_ent;
	tdt_pkg::entry_t                  new_ent;

	logic                             accept;
	logic                             out_free;
	logic                             setup_go;
	logic                             tick_go;
	logic                             slice_go;
	logic                             tid_ok;
	logic                             delay_go;
	logic                             drop_go;
	logic                             any_hit;
	logic                             expire;
	logic                             rotate;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	// the output slot is free when empty or being drained this cycle
	assign out_free      = !out_valid_q || m_axis_tready;

	assign setup_go = (state_q == ST_SETUP) && out_free;
	assign tick_go  = (state_q == ST_TICK) && (rem_q != '0) && out_free;
	assign slice_go = (state_q == ST_SLICE) && out_free;

	// a task beyond the table changes nothing but is still acknowledged
	assign tid_ok   = 32'(tid_q) < 32'(MAX_TASKS);
	assign delay_go = setup_go && tid_ok && (op_q == tdt_pkg::OP_DELAY);
	assign drop_go  = setup_go && tid_ok &&
	                  ((op_q == tdt_pkg::OP_WAKE) || (op_q == tdt_pkg::OP_REMOVE));
	assign any_hit  = hit_upto[MAX_TASKS-1];

	// head of the chain runs through the one decrementer; a delay of zero
	// wraps, so it lasts the full counter range
	always_comb begin
		head_ent       = ent[0];
		head_ent.count = ent[0].count - 1'b1;
	end
	assign expire = (head_ent.count == '0);

	assign new_ent = '{id: tid_q, count: ticks_q, ev: ev_q};

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		tdt_pkg::entry_t next_ent;
		logic            hit_prior;

		assign next_ent  = (i < MAX_TASKS - 1) ? ent[(i + 1) % MAX_TASKS] : '0;
		assign hit_prior = (i > 0) ? hit_upto[(i + MAX_TASKS - 1) % MAX_TASKS] : 1'b0;

		// a surviving head re-enters at the tail of the packed run;
		// an appended task lands just past it
		assign ctl[i].tick_step = tick_go;
		assign ctl[i].take_head = tick_go && !expire && (CNT_W'(i + 1) == cnt_q);
		assign ctl[i].drop      = drop_go;
		assign ctl[i].write     = delay_go &&
		                          (hit[i] || (!any_hit && (CNT_W'(i) == cnt_q)));

		tdt_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.next_ent  (next_ent),
			.head_ent  (head_ent),
			.new_ent   (new_ent),
			.active    (CNT_W'(i) < cnt_q),
			.tid       (tid_q),
			.hit_prior (hit_prior),
			.hit       (hit[i]),
			.hit_upto  (hit_upto[i]),
			.ent       (ent[i])
		);
	end

	tdt_slice #(
		.MAX_TASKS     (MAX_TASKS),
		.SLICE_DEFAULT (SLICE_DEFAULT)
	) u_slice (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (slice_go),
		.cur    (cur_q),
		.peers  (peers_q),
		.reload (reload_q),
		.rotate (rotate)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			reload_q    <= tdt_pkg::RELOAD_W'(SLICE_DEFAULT);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				reload_q <= cfg_wdata;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (tdt_pkg::op_t'(s_axis_tuser) == tdt_pkg::OP_TICK) begin
							state_q <= ST_TICK;
							rem_q   <= cnt_q;
						end else begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					if (setup_go) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TICK: begin
					if (rem_q == '0) begin
						state_q <= ST_SLICE;
					end else if (tick_go) begin
						rem_q <= rem_q - 1'b1;
					end
				end
				ST_SLICE: begin
					if (slice_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// set size: append on a new delay, shrink on drop or expiry
			if (delay_go && !any_hit && (cnt_q < CNT_W'(MAX_TASKS))) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (drop_go && any_hit) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (tick_go && expire) begin
				cnt_q <= cnt_q - 1'b1;
			end

			if (setup_go || slice_go || (tick_go && expire)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: latched op and result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= tdt_pkg::op_t'(s_axis_tuser);
			tid_q   <= s_axis_tdata[3:0];
			ticks_q <= s_axis_tdata[35:4];
			ev_q    <= s_axis_tdata[36];
			cur_q   <= s_axis_tdata[40:37];
			peers_q <= s_axis_tdata[41];
		end

		if (setup_go) begin
			out_kind_q <= tdt_pkg::KIND_ACK;
			out_task_q <= tid_q;
			out_tmo_q  <= 1'b0;
			out_rot_q  <= 1'b0;
			out_last_q <= 1'b1;
		end else if (tick_go && expire) begin
			out_kind_q <= tdt_pkg::KIND_WOKEN;
			out_task_q <= head_ent.id;
			out_tmo_q  <= head_ent.ev;
			out_rot_q  <= 1'b0;
			out_last_q <= 1'b0;
		end else if (slice_go) begin
			out_kind_q <= tdt_pkg::KIND_SLICE;
			out_task_q <= cur_q;
			out_tmo_q  <= 1'b0;
			out_rot_q  <= rotate;
			out_last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_rot_q, out_tmo_q, out_task_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
